// ===== src/semver_pkg.sv =====
`default_nettype none

package semver_pkg;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_LOW_V  = 8'h76;
  localparam logic [7:0] CH_UP_V   = 8'h56;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;

  localparam int unsigned OUT_NUM_W  = 64;
  localparam int unsigned PRE_CNT_W  = 6;
  localparam int unsigned TEXT_LEN_W = 7;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 208;

  typedef enum logic [1:0] {
    PH_CORE  = 2'd0,
    PH_PRE   = 2'd1,
    PH_BUILD = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [TEXT_LEN_W-1:0] text_length;
    logic                  has_build;
    logic [PRE_CNT_W-1:0]  prerelease_count;
    logic                  has_prerelease;
    logic [OUT_NUM_W-1:0]  patch_number;
    logic [OUT_NUM_W-1:0]  minor_number;
    logic [OUT_NUM_W-1:0]  major_number;
    logic                  version_valid;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_DASH);
  endfunction

endpackage

`default_nettype wire

// ===== src/semver_in_stage.sv =====
`default_nettype none

module semver_in_stage
  import semver_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire in_item_t item_i,
  input  wire logic     take_i,
  output logic          valid_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== src/semver_parse.sv =====
`default_nettype none

module semver_parse
  import semver_pkg::*;
#(
  parameter int unsigned MAX_TEXT_LEN = 64,
  parameter int unsigned NUMBER_BITS  = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire in_item_t item_i,
  output result_t       result_o
);

  localparam int unsigned LenW = $clog2(MAX_TEXT_LEN + 2);
  localparam int unsigned AccW = NUMBER_BITS + 4;
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_TEXT_LEN);

  typedef struct packed {
    logic [NUMBER_BITS-1:0] acc;
    logic [1:0]             len;
    logic                   all_dig;
    logic                   lead_zero;
    logic                   ovf;
  } ident_t;

  phase_e                 phase_q, phase_d;
  logic                   first_done_q, first_done_d;
  logic [LenW-1:0]        len_cnt_q, len_cnt_d;
  logic [1:0]             part_idx_q, part_idx_d;
  ident_t                 id_q, id_d, id_clr;
  logic [NUMBER_BITS-1:0] major_q, major_d;
  logic [NUMBER_BITS-1:0] minor_q, minor_d;
  logic [NUMBER_BITS-1:0] patch_q, patch_d;
  logic                   failed_q, failed_d;
  logic [PRE_CNT_W-1:0]   pre_cnt_q, pre_cnt_d;
  logic                   seen_dash_q, seen_dash_d;

  logic [7:0]             c;
  logic                   drop;
  logic [3:0]             dig;
  logic [AccW-1:0]        acc_ext, acc_mul;
  logic                   acc_fits;
  logic                   ok;
  logic [LenW-1:0]        len_lim;

  always_comb begin
    id_clr           = '0;
    id_clr.all_dig   = 1'b1;

    c        = item_i.text_byte;
    drop     = !first_done_q && ((c == CH_LOW_V) || (c == CH_UP_V));
    dig      = 4'(c - CH_ZERO);
    acc_ext  = {4'b0000, id_q.acc};
    acc_mul  = (acc_ext << 3) + (acc_ext << 1) + AccW'(dig);
    acc_fits = (acc_mul[AccW-1:NUMBER_BITS] == '0);

    phase_d      = phase_q;
    first_done_d = 1'b1;
    len_cnt_d    = len_cnt_q;
    part_idx_d   = part_idx_q;
    id_d         = id_q;
    major_d      = major_q;
    minor_d      = minor_q;
    patch_d      = patch_q;
    failed_d     = failed_q;
    pre_cnt_d    = pre_cnt_q;
    seen_dash_d  = seen_dash_q;

    // one character
    if (!drop) begin
      if (len_cnt_q <= LenMax) begin
        len_cnt_d = len_cnt_q + 1'b1;
      end
      case (phase_q)
        PH_CORE: begin
          if (is_digit(c)) begin
            if (id_q.lead_zero) failed_d = 1'b1;
            if ((id_q.len == 2'd0) && (dig == 4'd0)) id_d.lead_zero = 1'b1;
            if (acc_fits) id_d.acc = acc_mul[NUMBER_BITS-1:0];
            else failed_d = 1'b1;
            if (id_q.len != 2'd2) id_d.len = id_q.len + 1'b1;
          end else if (c == CH_DOT) begin
            if ((id_q.len == 2'd0) || (part_idx_q >= 2'd2)) failed_d = 1'b1;
            else if (part_idx_q == 2'd0) major_d = id_q.acc;
            else minor_d = id_q.acc;
            if (part_idx_q != 2'd3) part_idx_d = part_idx_q + 1'b1;
            id_d = id_clr;
          end else if ((c == CH_DASH) || (c == CH_PLUS)) begin
            if ((part_idx_q != 2'd2) || (id_q.len == 2'd0)) failed_d = 1'b1;
            else patch_d = id_q.acc;
            id_d = id_clr;
            if (c == CH_DASH) begin
              seen_dash_d = 1'b1;
              phase_d     = PH_PRE;
            end else begin
              phase_d = PH_BUILD;
            end
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_PRE: begin
          if ((c == CH_DOT) || (c == CH_PLUS)) begin
            if (id_q.len == 2'd0) failed_d = 1'b1;
            else if (id_q.all_dig && ((id_q.lead_zero && (id_q.len == 2'd2)) || id_q.ovf))
              failed_d = 1'b1;
            if (pre_cnt_q != '1) pre_cnt_d = pre_cnt_q + 1'b1;
            id_d = id_clr;
            if (c == CH_PLUS) phase_d = PH_BUILD;
          end else if (is_ident_char(c)) begin
            if (is_digit(c)) begin
              if ((id_q.len == 2'd0) && (dig == 4'd0)) id_d.lead_zero = 1'b1;
              if (id_q.all_dig) begin
                if (acc_fits) id_d.acc = acc_mul[NUMBER_BITS-1:0];
                else id_d.ovf = 1'b1;
              end
            end else begin
              id_d.all_dig = 1'b0;
            end
            if (id_q.len != 2'd2) id_d.len = id_q.len + 1'b1;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_BUILD: begin
          if (c == CH_DOT) begin
            if (id_q.len == 2'd0) failed_d = 1'b1;
            id_d = id_clr;
          end else if ((c == CH_PLUS) || !is_ident_char(c)) begin
            failed_d = 1'b1;
          end else if (id_q.len != 2'd2) begin
            id_d.len = id_q.len + 1'b1;
          end
        end
        default: begin
          failed_d = 1'b1;
        end
      endcase
    end

    // close the open part at the end of the string
    if (item_i.end_of_text) begin
      case (phase_d)
        PH_CORE: begin
          if ((part_idx_d != 2'd2) || (id_d.len == 2'd0)) failed_d = 1'b1;
          else patch_d = id_d.acc;
        end
        PH_PRE: begin
          if (id_d.len == 2'd0) failed_d = 1'b1;
          else if (id_d.all_dig && ((id_d.lead_zero && (id_d.len == 2'd2)) || id_d.ovf))
            failed_d = 1'b1;
          if (pre_cnt_d != '1) pre_cnt_d = pre_cnt_d + 1'b1;
        end
        default: begin
          if (id_d.len == 2'd0) failed_d = 1'b1;
        end
      endcase
    end

    ok      = !failed_d && (len_cnt_d != '0) && (len_cnt_d <= LenMax);
    len_lim = (len_cnt_d > LenMax) ? LenMax : len_cnt_d;

    result_o.version_valid    = ok;
    result_o.major_number     = ok ? OUT_NUM_W'(major_d) : '0;
    result_o.minor_number     = ok ? OUT_NUM_W'(minor_d) : '0;
    result_o.patch_number     = ok ? OUT_NUM_W'(patch_d) : '0;
    result_o.has_prerelease   = ok && seen_dash_d;
    result_o.prerelease_count = ok ? pre_cnt_d : '0;
    result_o.has_build        = ok && (phase_d == PH_BUILD);
    result_o.text_length      = (32'(len_lim) > 32'd127) ? TEXT_LEN_W'(127)
                                                         : TEXT_LEN_W'(len_lim);

    // fresh state for the next string
    if (item_i.end_of_text) begin
      phase_d      = PH_CORE;
      first_done_d = 1'b0;
      len_cnt_d    = '0;
      part_idx_d   = '0;
      id_d         = id_clr;
      major_d      = '0;
      minor_d      = '0;
      patch_d      = '0;
      failed_d     = 1'b0;
      pre_cnt_d    = '0;
      seen_dash_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_CORE;
      first_done_q <= 1'b0;
      len_cnt_q    <= '0;
      part_idx_q   <= '0;
      id_q         <= '{acc: '0, len: 2'd0, all_dig: 1'b1, lead_zero: 1'b0, ovf: 1'b0};
      major_q      <= '0;
      minor_q      <= '0;
      patch_q      <= '0;
      failed_q     <= 1'b0;
      pre_cnt_q    <= '0;
      seen_dash_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      first_done_q <= first_done_d;
      len_cnt_q    <= len_cnt_d;
      part_idx_q   <= part_idx_d;
      id_q         <= id_d;
      major_q      <= major_d;
      minor_q      <= minor_d;
      patch_q      <= patch_d;
      failed_q     <= failed_d;
      pre_cnt_q    <= pre_cnt_d;
      seen_dash_q  <= seen_dash_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.end_of_text |=> (phase_q == PH_CORE) && !first_done_q && !failed_q)
    else $error("state not cleared after end of string");

  a_valid_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.end_of_text && result_o.version_valid |-> result_o.text_length != '0)
    else $error("valid result with empty text");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.end_of_text && !result_o.version_valid |->
      (result_o.major_number == '0) && (result_o.prerelease_count == '0) &&
      !result_o.has_build && !result_o.has_prerelease)
    else $error("invalid result carries fields");

  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_cnt_q <= LenW'(MAX_TEXT_LEN + 1))
    else $error("length count beyond saturation");

endmodule

`default_nettype wire

// ===== src/semver_out_stage.sv =====
`default_nettype none

module semver_out_stage
  import semver_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  output logic         free_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== src/semver_string_validator_unit.sv =====
// channel  | dir | handshake                    | payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: text_byte; tlast: end_of_text
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: result fields, see port list
//
// one byte per cycle while no last byte waits on a full result register: input register, then
// parsing logic into the result register, loaded as the last byte leaves the input register
// the x10 add on the number accumulator sets the parsing path
// rst_ni clears the handshake flags and the parser state; the string restarts
// a stalled result holds only bytes marked last; other bytes keep flowing
`default_nettype none

module semver_string_validator_unit
  import semver_pkg::*;
#(
  parameter int unsigned MAX_TEXT_LEN = 64,
  parameter int unsigned NUMBER_BITS  = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [7:0] text_byte
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [0] version_valid, [64:1] major_number, [128:65] minor_number,
  // [192:129] patch_number, [193] has_prerelease, [199:194] prerelease_count,
  // [200] has_build, [207:201] text_length
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  in_item_t in_item, stage_item;
  logic     stage_valid, out_free, fire;
  result_t  parse_res, out_res;

  assign in_item.text_byte   = s_axis_tdata;
  assign in_item.end_of_text = s_axis_tlast;

  assign fire = stage_valid && (!stage_item.end_of_text || out_free);

  semver_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .take_i  (fire),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  semver_parse #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN),
    .NUMBER_BITS  (NUMBER_BITS)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage_item),
    .result_o (parse_res)
  );

  semver_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire && stage_item.end_of_text),
    .result_i (parse_res),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_res)
  );

  assign m_axis_tdata = out_res;

endmodule

`default_nettype wire

// ===== tb/sv/semver_result_checker.sv =====
`default_nettype none

module semver_result_checker
  import semver_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                  s_axis_tlast,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int unsigned                mismatch_count_o,
  output int unsigned                results_due_o
);

  localparam int unsigned TEXT_LIMIT = 64;

  phase_e               parse_phase;
  bit                   started;
  int unsigned          text_len;
  int unsigned          core_idx;
  logic [OUT_NUM_W-1:0] acc;
  logic [OUT_NUM_W-1:0] major_q;
  logic [OUT_NUM_W-1:0] minor_q;
  logic [OUT_NUM_W-1:0] patch_q;
  int unsigned          id_len;
  bit                   id_digits;
  bit                   id_lead_zero;
  bit                   id_ovf;
  bit                   bad;
  bit                   saw_dash;
  int unsigned          pre_count;

  result_t versions_due[$];

  function automatic bit decimal_char(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic bit name_char(input logic [7:0] c);
    return decimal_char(c) || ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_DASH);
  endfunction

  // false when the next digit would overflow the number
  function automatic bit append_digit(input logic [3:0] d);
    logic [OUT_NUM_W-1:0] bound;
    bound = ({OUT_NUM_W{1'b1}} - OUT_NUM_W'(d)) / OUT_NUM_W'(10);
    if (acc > bound) return 1'b0;
    acc = acc * OUT_NUM_W'(10) + OUT_NUM_W'(d);
    return 1'b1;
  endfunction

  task automatic clear_ident();
    acc          = '0;
    id_len       = 0;
    id_digits    = 1'b1;
    id_lead_zero = 1'b0;
    id_ovf       = 1'b0;
  endtask

  task automatic clear_parser();
    parse_phase = PH_CORE;
    started     = 1'b0;
    text_len    = 0;
    core_idx    = 0;
    major_q     = '0;
    minor_q     = '0;
    patch_q     = '0;
    bad         = 1'b0;
    pre_count   = 0;
    saw_dash    = 1'b0;
    clear_ident();
  endtask

  task automatic grow_ident();
    if (id_len < 127) id_len++;
  endtask

  task automatic close_core();
    if (core_idx != 2 || id_len == 0) bad = 1'b1;
    else patch_q = acc;
    clear_ident();
  endtask

  task automatic close_pre_ident();
    if (id_len == 0) bad = 1'b1;
    else if (id_digits && ((id_lead_zero && id_len > 1) || id_ovf)) bad = 1'b1;
    if (pre_count < 63) pre_count++;
    clear_ident();
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [3:0] d;
    d = 4'(c - CH_ZERO);
    if (text_len <= TEXT_LIMIT) text_len++;
    case (parse_phase)
      PH_CORE: begin
        if (decimal_char(c)) begin
          if (id_lead_zero) bad = 1'b1;
          if (id_len == 0 && d == 0) id_lead_zero = 1'b1;
          if (!append_digit(d)) bad = 1'b1;
          grow_ident();
        end else if (c == CH_DOT) begin
          if (id_len == 0 || core_idx >= 2) bad = 1'b1;
          else if (core_idx == 0) major_q = acc;
          else minor_q = acc;
          if (core_idx < 3) core_idx++;
          clear_ident();
        end else if (c == CH_DASH) begin
          close_core();
          saw_dash    = 1'b1;
          parse_phase = PH_PRE;
        end else if (c == CH_PLUS) begin
          close_core();
          parse_phase = PH_BUILD;
        end else begin
          bad = 1'b1;
        end
      end
      PH_PRE: begin
        if (c == CH_DOT) begin
          close_pre_ident();
        end else if (c == CH_PLUS) begin
          close_pre_ident();
          parse_phase = PH_BUILD;
        end else if (name_char(c)) begin
          if (decimal_char(c)) begin
            if (id_len == 0 && d == 0) id_lead_zero = 1'b1;
            if (id_digits) begin
              if (!append_digit(d)) id_ovf = 1'b1;
            end
          end else begin
            id_digits = 1'b0;
          end
          grow_ident();
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        if (c == CH_DOT) begin
          if (id_len == 0) bad = 1'b1;
          clear_ident();
        end else if (c == CH_PLUS || !name_char(c)) begin
          bad = 1'b1;
        end else begin
          grow_ident();
        end
      end
    endcase
  endtask

  task automatic take_transfer(input logic [7:0] c, input logic last);
    result_t r;
    bit      ok;
    if (!(!started && (c == CH_LOW_V || c == CH_UP_V))) parse_char(c);
    started = 1'b1;
    if (last) begin
      if (parse_phase == PH_CORE) close_core();
      else if (parse_phase == PH_PRE) close_pre_ident();
      else if (id_len == 0) bad = 1'b1;
      ok = !bad && text_len >= 1 && text_len <= TEXT_LIMIT;
      r = '0;
      r.text_length = TEXT_LEN_W'((text_len > TEXT_LIMIT) ? TEXT_LIMIT : text_len);
      if (ok) begin
        r.version_valid    = 1'b1;
        r.major_number     = major_q;
        r.minor_number     = minor_q;
        r.patch_number     = patch_q;
        r.has_prerelease   = saw_dash;
        r.prerelease_count = PRE_CNT_W'(pre_count);
        r.has_build        = (parse_phase == PH_BUILD);
      end
      versions_due.insert(versions_due.size(), r);
      clear_parser();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count_o++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  task automatic check_version(input result_t got);
    result_t want;
    if (versions_due.size() == 0) begin
      report_mismatch($sformatf("result with no string pending, tdata %h", got));
    end else begin
      want = versions_due.pop_front();
      check_field("version_valid", 64'(want.version_valid), 64'(got.version_valid));
      check_field("major_number", want.major_number, got.major_number);
      check_field("minor_number", want.minor_number, got.minor_number);
      check_field("patch_number", want.patch_number, got.patch_number);
      check_field("has_prerelease", 64'(want.has_prerelease), 64'(got.has_prerelease));
      check_field("prerelease_count", 64'(want.prerelease_count),
                  64'(got.prerelease_count));
      check_field("has_build", 64'(want.has_build), 64'(got.has_build));
      check_field("text_length", 64'(want.text_length), 64'(got.text_length));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      versions_due.delete();
      mismatch_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_version(result_t'(m_axis_tdata));
      if (s_axis_tvalid && s_axis_tready) take_transfer(s_axis_tdata, s_axis_tlast);
    end
    results_due_o = versions_due.size();
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
  import semver_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1550;
  localparam int unsigned QUIET_LIMIT  = 2000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCKED
  } rx_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int unsigned mismatches;
  int unsigned results_due;

  logic [7:0]  text_q[$];
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  semver_string_validator_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  semver_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatch_count_o(mismatches),
    .results_due_o   (results_due)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= (rx_mode == RX_BLOCKED) ? RX_OPEN : rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:    m_axis_tready <= 1'b1;
      RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE:  m_axis_tready <= (rx_tick % 8 == 0);
      default:    m_axis_tready <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] ident_char();
    int k;
    k = $urandom_range(0, 62);
    if (k < 10) return CH_ZERO + 8'(k);
    if (k < 36) return CH_LOW_A + 8'(k - 10);
    if (k < 62) return CH_UP_A + 8'(k - 36);
    return CH_DASH;
  endfunction

  task automatic append_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  task automatic put_number();
    logic [63:0] v;
    case ($urandom_range(0, 11))
      0:       v = '0;
      1:       v = $urandom_range(0, 99999);
      2:       v = {$urandom, $urandom};
      3:       v = '1;
      4, 5:    v = $urandom_range(1, 9);
      default: v = $urandom_range(0, 99);
    endcase
    put_str($sformatf("%0d", v));
  endtask

  task automatic put_ident();
    if ($urandom_range(0, 2) == 0) begin
      put_str($sformatf("%0d", $urandom_range(0, 500)));
    end else begin
      repeat ($urandom_range(1, 6)) append_byte(ident_char());
    end
  endtask

  task automatic put_version();
    int n;
    if ($urandom_range(0, 3) == 0) append_byte($urandom_range(0, 1) ? CH_LOW_V : CH_UP_V);
    put_number();
    append_byte(CH_DOT);
    put_number();
    append_byte(CH_DOT);
    put_number();
    if ($urandom_range(0, 1) == 1) begin
      append_byte(CH_DASH);
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if (i > 0) append_byte(CH_DOT);
        put_ident();
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      append_byte(CH_PLUS);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) append_byte(CH_DOT);
        put_ident();
      end
    end
  endtask

  task automatic spoil_text();
    logic [7:0] marks[4];
    int         pos;
    marks = '{CH_DOT, CH_PLUS, CH_DASH, CH_ZERO};
    pos = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 4))
      0: text_q[pos] = 8'($urandom_range(0, 255));
      1: text_q.insert(pos, marks[$urandom_range(0, 3)]);
      2: if (text_q.size() > 1) text_q.delete(pos);
      3: repeat ($urandom_range(1, 70)) append_byte(ident_char());
      default: append_byte(marks[$urandom_range(0, 3)]);
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (results_due != 0) @(negedge clk_i);
    @(posedge clk_i);
    burst_left = $urandom_range(1, 40);
  endtask

  initial begin
    string samples[$];
    samples = '{"1.2.3", "v0.0.0", "V1.0.0-alpha.1+build.5", "v", "1.v.3",
                "18446744073709551615.18446744073709551615.18446744073709551615",
                "18446744073709551616.0.0", "01.2.3", "1.2", "1.2.3.4", "1.2.3-",
                "1.2.3-01", "1.2.3-0a.x-y", "1.2.3+a+b", "1.2.3-rc.18446744073709551616",
                "1.2.3+"};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (samples[i]) begin
      text_q.delete();
      put_str(samples[i]);
      send_text();
    end
    // byte above 127, exactly full length, one byte over, many prerelease parts
    text_q.delete();
    put_str("1.2.");
    append_byte(8'hff);
    send_text();
    text_q.delete();
    put_str("1.2.3-");
    repeat (58) append_byte(CH_LOW_A);
    send_text();
    text_q.delete();
    put_str("v1.2.3-");
    repeat (59) append_byte(CH_UP_A);
    send_text();
    text_q.delete();
    put_str("1.2.3-a");
    repeat (28) put_str(".b");
    send_text();
    hold_until_drained();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      text_q.delete();
      case ($urandom_range(0, 9))
        0:       repeat ($urandom_range(1, 12)) append_byte(8'($urandom_range(0, 255)));
        1, 2: begin
          put_version();
          spoil_text();
        end
        default: put_version();
      endcase
      send_text();
      if (bytes_sent >= RANDOM_BYTES / 2 && bytes_sent < RANDOM_BYTES / 2 + 80) begin
        hold_until_drained();
      end
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (results_due != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && results_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/semver_pkg.sv
src/semver_in_stage.sv
src/semver_parse.sv
src/semver_out_stage.sv
src/semver_string_validator_unit.sv
tb/sv/semver_result_checker.sv
tb/sv/tb_top.sv
